/* rtl/usb_tablet_report_engine_assert.svh */
// ---------------------------------------------------------------------------
// USB tablet report engine assertion macros
// Shared concurrent assertion forms; they compile away in synthesis.
// ---------------------------------------------------------------------------
`ifndef USB_TABLET_REPORT_ENGINE_ASSERT_SVH
`define USB_TABLET_REPORT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked out of reset.
`define UTRE_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, checked out of reset.
`define UTRE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("next-cycle implication check failed");

`else

`define UTRE_ASSERT_IMPLY(label, clk, rst_n, pre, post)
`define UTRE_ASSERT_NEXT(label, clk, rst_n, pre, post)

`endif

`endif

/* rtl/utre_pkg.sv */
// ---------------------------------------------------------------------------
// USB tablet report engine package
// Shared types, codes and widths of the report engine.
// ---------------------------------------------------------------------------
package utre_pkg;

    // Motion and wheel accumulator width.
    localparam int ACCUM_W = 16;
    localparam int SUM_W   = ((ACCUM_W > 16) ? ACCUM_W : 16) + 1;

    typedef logic signed [ACCUM_W-1:0] accum_t;

    localparam accum_t ACC_MAX  = {1'b0, {(ACCUM_W-1){1'b1}}};
    localparam accum_t ACC_MIN  = {1'b1, {(ACCUM_W-1){1'b0}}};
    localparam accum_t CLAMP_HI = accum_t'(127);
    localparam accum_t CLAMP_LO = accum_t'(-128);

    // Command queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Longest response in words.
    localparam int RESP_MAX = 7;

    // Input mode codes.
    localparam logic [2:0] MODE_REL   = 3'd0;
    localparam logic [2:0] MODE_ABS   = 3'd1;
    localparam logic [2:0] MODE_CTRL  = 3'd2;
    localparam logic [2:0] MODE_IN    = 3'd3;
    localparam logic [2:0] MODE_OUT   = 3'd4;
    localparam logic [2:0] MODE_RESET = 3'd5;

    // Control request codes, type in the high byte.
    localparam logic [15:0] REQ_SET_FORMAT = 16'h2109;
    localparam logic [15:0] REQ_GET_FORMAT = 16'h2101;
    localparam logic [15:0] REQ_GET_REPORT = 16'ha101;
    localparam logic [15:0] REQ_GET_IDLE   = 16'ha102;
    localparam logic [15:0] REQ_SET_IDLE   = 16'h210a;

    // Handshake status codes.
    localparam logic [1:0] ST_ACK   = 2'd0;
    localparam logic [1:0] ST_NAK   = 2'd1;
    localparam logic [1:0] ST_STALL = 2'd2;

    // Report formats.
    localparam logic [7:0] FMT_REL = 8'd1;
    localparam logic [7:0] FMT_ABS = 8'd2;

    localparam logic [3:0] REPORT_EP = 4'd1;

    // Absolute position scaling.
    localparam int POSX_W = 13;
    localparam int POSY_W = 12;
    localparam int PX_W   = 15 + POSX_W;
    localparam int PY_W   = 15 + POSY_W;
    localparam logic [POSX_W-1:0] SCALE_X  = 13'd5040;
    localparam logic [POSY_W-1:0] SCALE_Y  = 12'd3780;
    localparam logic [15:0]       ABS_FULL = 16'h7FFF;

    // Absolute report button bytes.
    localparam logic [7:0] ABS_RIGHT  = 8'h40;
    localparam logic [7:0] ABS_MIDDLE = 8'h20;
    localparam logic [7:0] ABS_NOTIP  = 8'h81;

    // One input word.
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [15:0] delta_x;
        logic signed [15:0] delta_y;
        logic [14:0]        abs_x;
        logic [14:0]        abs_y;
        logic signed [15:0] wheel_delta;
        logic [2:0]         buttons;
        logic [15:0]        request_code;
        logic [15:0]        request_value;
        logic [7:0]         request_data;
        logic [15:0]        buffer_length;
        logic [3:0]         endpoint;
    } item_t;

    // One result word.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] byte_count;
        logic       has_byte;
        logic [7:0] byte_value;
        logic       last;
    } result_t;

    // Classified command kinds.
    typedef enum logic [3:0] {
        K_REL,
        K_ABS,
        K_SET_FMT,
        K_GET_FMT,
        K_GET_REPORT,
        K_GET_IDLE,
        K_SET_IDLE,
        K_STALL,
        K_IN,
        K_RESET
    } cmd_kind_t;

    // Classified command, front to back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] wheel;
        logic [2:0]         buttons;
        logic [PX_W-1:0]    px;
        logic [PY_W-1:0]    py;
        logic [7:0]         data;
        logic [2:0]         len_cap;
    } cmd_t;

    // Complete response, back to serializer.
    typedef struct packed {
        logic [1:0]                    status;
        logic [2:0]                    n;
        logic [RESP_MAX-1:0][7:0]      bytes;
    } resp_t;

endpackage

/* rtl/utre_front.sv */
// ---------------------------------------------------------------------------
// USB tablet report engine front end
// Takes input words, decodes them into commands and starts position scaling.
// ---------------------------------------------------------------------------
module utre_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  utre_pkg::item_t item,
    output logic           q_push,
    output utre_pkg::cmd_t q_data,
    input  logic           q_full
);
    import utre_pkg::*;

    logic  stage_valid_reg;
    logic  stage_valid_next;
    cmd_t  cmd_reg;
    cmd_t  cmd_dec;
    logic  keep;
    logic  accept;

    // The stage holds while the queue is full.
    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = stage_valid_reg && !q_full;
    assign q_data = cmd_reg;

    // Decode the word into a command; unused modes are dropped.
    always_comb
    begin
        cmd_dec         = '0;
        cmd_dec.kind    = K_STALL;
        cmd_dec.dx      = item.delta_x;
        cmd_dec.dy      = item.delta_y;
        cmd_dec.wheel   = item.wheel_delta;
        cmd_dec.buttons = item.buttons;
        cmd_dec.px      = PX_W'(item.abs_x) * PX_W'(SCALE_X);
        cmd_dec.py      = PY_W'(item.abs_y) * PY_W'(SCALE_Y);
        cmd_dec.data    = item.request_data;
        cmd_dec.len_cap = (item.buffer_length > 16'd7) ? 3'd7 : item.buffer_length[2:0];
        keep            = 1'b1;
        unique case (item.mode)
            MODE_REL:   cmd_dec.kind = K_REL;
            MODE_ABS:   cmd_dec.kind = K_ABS;
            MODE_CTRL:
            begin
                unique case (item.request_code)
                    REQ_SET_FORMAT: cmd_dec.kind = K_SET_FMT;
                    REQ_GET_FORMAT: cmd_dec.kind = K_GET_FMT;
                    REQ_GET_REPORT: cmd_dec.kind = K_GET_REPORT;
                    REQ_GET_IDLE:   cmd_dec.kind = K_GET_IDLE;
                    REQ_SET_IDLE:
                    begin
                        cmd_dec.kind = K_SET_IDLE;
                        cmd_dec.data = item.request_value[15:8];
                    end
                    default:        cmd_dec.kind = K_STALL;
                endcase
            end
            MODE_IN:    cmd_dec.kind = (item.endpoint == REPORT_EP) ? K_IN : K_STALL;
            MODE_OUT:   cmd_dec.kind = K_STALL;
            MODE_RESET: cmd_dec.kind = K_RESET;
            default:    keep = 1'b0;
        endcase
    end

    // Stage occupancy.
    always_comb
    begin
        if (accept)
        begin
            stage_valid_next = keep;
        end
        else
        begin
            stage_valid_next = stage_valid_reg && !q_push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Command payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_dec;
        end
    end

endmodule

/* rtl/utre_queue.sv */
// ---------------------------------------------------------------------------
// USB tablet report engine command queue
// Short first-in first-out buffer between the front end and execution.
// ---------------------------------------------------------------------------
module utre_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  utre_pkg::cmd_t wr_data,
    output logic           q_full,
    input  logic           rd_en,
    output utre_pkg::cmd_t rd_data,
    output logic           q_empty
);
    import utre_pkg::*;

    cmd_t              slots_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign q_full  = (count_reg == QCNT_W'(QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slots_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/utre_exec.sv */
// ---------------------------------------------------------------------------
// USB tablet report engine execution unit
// Holds the pointer state, applies commands and builds complete responses.
// ---------------------------------------------------------------------------
module utre_exec (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  utre_pkg::cmd_t  q_data,
    output logic            q_pop,
    output logic            desc_valid,
    output utre_pkg::resp_t desc,
    input  logic            desc_ready
);
    import utre_pkg::*;

    accum_t              accum_dx_reg;
    accum_t              accum_dx_next;
    accum_t              accum_dy_reg;
    accum_t              accum_dy_next;
    accum_t              accum_wheel_reg;
    accum_t              accum_wheel_next;
    logic [2:0]          buttons_reg;
    logic [2:0]          buttons_next;
    logic [POSX_W-1:0]   pos_x_reg;
    logic [POSX_W-1:0]   pos_x_next;
    logic [POSY_W-1:0]   pos_y_reg;
    logic [POSY_W-1:0]   pos_y_next;
    logic [7:0]          format_reg;
    logic [7:0]          format_next;
    logic [7:0]          idle_reg;
    logic [7:0]          idle_next;
    logic                pending_reg;
    logic                pending_next;

    accum_t                   take_dx;
    accum_t                   take_dy;
    accum_t                   take_wheel;
    logic [2:0]               rpt_n;
    logic [RESP_MAX-1:0][7:0] rpt_bytes;
    logic                     rpt_drain;
    logic                     needs_resp;
    logic                     go;
    logic                     report_ok;
    logic [7:0]               abs_hi;
    cmd_t                     cmd;

    // Signed add that sticks at the accumulator range.
    function automatic accum_t sat_add(accum_t acc, logic signed [15:0] d);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(d);
        if (s > SUM_W'(ACC_MAX))
        begin
            return ACC_MAX;
        end
        else if (s < SUM_W'(ACC_MIN))
        begin
            return ACC_MIN;
        end
        return s[ACCUM_W-1:0];
    endfunction

    // Part of an accumulator that fits in one report byte.
    function automatic accum_t clamp8(accum_t acc);
        if (acc > CLAMP_HI)
        begin
            return CLAMP_HI;
        end
        else if (acc < CLAMP_LO)
        begin
            return CLAMP_LO;
        end
        return acc;
    endfunction

    // Division of a scaled position by 0x7FFF: shift, then one correction.
    function automatic logic [POSX_W-1:0] div_full(logic [PX_W-1:0] p);
        logic [POSX_W-1:0] q0;
        logic [15:0]       r;
        q0 = p[PX_W-1:15];
        r  = 16'(p[14:0]) + 16'(q0);
        return q0 + POSX_W'(r >= ABS_FULL);
    endfunction

    // Response length cut to the host buffer.
    function automatic logic [2:0] cut_len(logic [2:0] n, logic [2:0] len);
        return (len < n) ? len : n;
    endfunction

    assign cmd = q_data;

    // Report contents for the current format.
    always_comb
    begin
        take_dx    = clamp8(accum_dx_reg);
        take_dy    = clamp8(accum_dy_reg);
        take_wheel = clamp8(accum_wheel_reg);
        rpt_bytes  = '0;
        rpt_n      = 3'd0;
        rpt_drain  = 1'b0;
        abs_hi     = (buttons_reg[1] ? ABS_RIGHT : 8'h00) | (buttons_reg[2] ? ABS_MIDDLE : 8'h00);
        if (format_reg == FMT_REL)
        begin
            rpt_drain    = 1'b1;
            rpt_bytes[0] = {5'b0, buttons_reg};
            rpt_bytes[1] = take_dx[7:0];
            rpt_bytes[2] = take_dy[7:0];
            rpt_bytes[3] = take_wheel[7:0];
            rpt_n        = (cmd.len_cap >= 3'd4) ? 3'd4 : 3'd3;
        end
        else if (format_reg == FMT_ABS)
        begin
            rpt_bytes[0] = format_reg;
            rpt_bytes[1] = pos_x_reg[7:0];
            rpt_bytes[2] = 8'(pos_x_reg[POSX_W-1:8]);
            rpt_bytes[3] = pos_y_reg[7:0];
            rpt_bytes[4] = 8'(pos_y_reg[POSY_W-1:8]);
            rpt_bytes[5] = abs_hi;
            rpt_bytes[6] = (buttons_reg[0] || buttons_reg[2]) ? 8'h00 : ABS_NOTIP;
            rpt_n        = (cmd.len_cap == 3'd7) ? 3'd7 : 3'd0;
        end
    end

    // Handshake with the queue and the serializer.
    always_comb
    begin
        needs_resp = !((cmd.kind == K_REL) || (cmd.kind == K_ABS) || (cmd.kind == K_RESET));
        go         = !q_empty && (!needs_resp || desc_ready);
        q_pop      = go;
        desc_valid = !q_empty && needs_resp;
        report_ok  = pending_reg || (idle_reg != 8'd0);
    end

    // Command execution: next state and response.
    always_comb
    begin
        accum_dx_next    = accum_dx_reg;
        accum_dy_next    = accum_dy_reg;
        accum_wheel_next = accum_wheel_reg;
        buttons_next     = buttons_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        format_next      = format_reg;
        idle_next        = idle_reg;
        pending_next     = pending_reg;
        desc             = '0;
        desc.status      = ST_ACK;
        unique case (cmd.kind)
            K_REL:
            begin
                accum_dx_next    = sat_add(accum_dx_reg, cmd.dx);
                accum_dy_next    = sat_add(accum_dy_reg, cmd.dy);
                accum_wheel_next = sat_add(accum_wheel_reg, cmd.wheel);
                buttons_next     = cmd.buttons;
                pending_next     = 1'b1;
            end
            K_ABS:
            begin
                pos_x_next       = div_full(cmd.px);
                pos_y_next       = POSY_W'(div_full(PX_W'(cmd.py)));
                accum_wheel_next = sat_add(accum_wheel_reg, cmd.wheel);
                buttons_next     = cmd.buttons;
                pending_next     = 1'b1;
            end
            K_SET_FMT:
            begin
                format_next = cmd.data;
            end
            K_GET_FMT:
            begin
                desc.n        = cut_len(3'd2, cmd.len_cap);
                desc.bytes[1] = format_reg;
            end
            K_GET_REPORT:
            begin
                desc.n     = cut_len(rpt_n, cmd.len_cap);
                desc.bytes = rpt_bytes;
                if (rpt_drain)
                begin
                    accum_dx_next    = accum_dx_reg - take_dx;
                    accum_dy_next    = accum_dy_reg - take_dy;
                    accum_wheel_next = accum_wheel_reg - take_wheel;
                end
            end
            K_GET_IDLE:
            begin
                desc.n        = cut_len(3'd1, cmd.len_cap);
                desc.bytes[0] = idle_reg;
            end
            K_SET_IDLE:
            begin
                idle_next = cmd.data;
            end
            K_STALL:
            begin
                desc.status = ST_STALL;
            end
            K_IN:
            begin
                if (!report_ok)
                begin
                    desc.status = ST_NAK;
                end
                else
                begin
                    pending_next = 1'b0;
                    desc.n       = cut_len(rpt_n, cmd.len_cap);
                    desc.bytes   = rpt_bytes;
                    if (rpt_drain)
                    begin
                        accum_dx_next    = accum_dx_reg - take_dx;
                        accum_dy_next    = accum_dy_reg - take_dy;
                        accum_wheel_next = accum_wheel_reg - take_wheel;
                    end
                end
            end
            K_RESET:
            begin
                accum_dx_next    = '0;
                accum_dy_next    = '0;
                accum_wheel_next = '0;
                buttons_next     = '0;
                pos_x_next       = '0;
                pos_y_next       = '0;
                format_next      = FMT_REL;
            end
            default:
            begin
                desc.status = ST_STALL;
            end
        endcase
    end

    // State registers, updated when a command retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_dx_reg    <= '0;
            accum_dy_reg    <= '0;
            accum_wheel_reg <= '0;
            buttons_reg     <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            format_reg      <= FMT_REL;
            idle_reg        <= '0;
            pending_reg     <= 1'b1;
        end
        else if (go)
        begin
            accum_dx_reg    <= accum_dx_next;
            accum_dy_reg    <= accum_dy_next;
            accum_wheel_reg <= accum_wheel_next;
            buttons_reg     <= buttons_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            format_reg      <= format_next;
            idle_reg        <= idle_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

/* rtl/utre_serial.sv */
// ---------------------------------------------------------------------------
// USB tablet report engine serializer
// Sends a response one byte word per cycle while the output is popped, through an output register.
// ---------------------------------------------------------------------------
module utre_serial (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              desc_valid,
    input  utre_pkg::resp_t   desc,
    output logic              desc_ready,
    output logic              empty,
    input  logic              pop,
    output utre_pkg::result_t result
);
    import utre_pkg::*;

    logic    busy_reg;
    logic    busy_next;
    resp_t   desc_reg;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_reg;
    result_t word;
    logic    out_load;
    logic    is_last;
    logic    finishing;
    logic    take_desc;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    // Current word of the held response.
    always_comb
    begin
        is_last         = (desc_reg.n == 3'd0) || (idx_reg == desc_reg.n - 3'd1);
        word.status     = desc_reg.status;
        word.byte_count = desc_reg.n;
        word.has_byte   = (desc_reg.n != 3'd0);
        word.byte_value = (desc_reg.n != 3'd0) ? desc_reg.bytes[idx_reg] : 8'h00;
        word.last       = is_last;
    end

    // Output register and response sequencing.
    always_comb
    begin
        out_load       = !out_valid_reg || pop;
        finishing      = busy_reg && out_load && is_last;
        desc_ready     = !busy_reg || finishing;
        take_desc      = desc_valid && desc_ready;
        out_valid_next = out_valid_reg;
        idx_next       = idx_reg;
        if (busy_reg && out_load)
        begin
            out_valid_next = 1'b1;
            idx_next       = is_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (out_load)
        begin
            out_valid_next = 1'b0;
        end
        if (take_desc)
        begin
            idx_next = 3'd0;
        end
        busy_next = take_desc ? 1'b1 : (finishing ? 1'b0 : busy_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (take_desc)
        begin
            desc_reg <= desc;
        end
        if (busy_reg && out_load)
        begin
            out_reg <= word;
        end
    end

endmodule

/* rtl/usb_tablet_report_engine.sv */
// Path: an input word passes the front stage register, a queue slot, the held response and
// the output register. Throughput: one input word per cycle while full is low; the output sends
// one word per cycle while pop is held; an n-byte response is n words, one without bytes is one.
// Pointer events keep executing while a response streams out, set by the 4-entry command queue.
// Reset: rst_n clears control state asynchronously; format 1, idle rate 0, change pending.
// ---------------------------------------------------------------------------
// USB tablet report engine
// Pointer report engine with relative and absolute report formats.
// ---------------------------------------------------------------------------
`include "usb_tablet_report_engine_assert.svh"

module usb_tablet_report_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  utre_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output utre_pkg::result_t result
);
    import utre_pkg::*;

    logic  q_push;
    logic  q_full;
    cmd_t  q_wdata;
    logic  q_pop;
    logic  q_empty;
    cmd_t  q_rdata;
    logic  desc_valid;
    logic  desc_ready;
    resp_t desc;

    // Decode stage.
    utre_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_data (q_wdata),
        .q_full (q_full)
    );

    // Command queue.
    utre_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    // State and response builder.
    utre_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_ready (desc_ready)
    );

    // Byte serializer.
    utre_serial u_serial (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_ready (desc_ready),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    // Queue and result checks.
    `UTRE_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, q_push, !q_full)
    `UTRE_ASSERT_IMPLY(a_no_pop_when_empty, clk, rst_n, q_pop, !q_empty)
    `UTRE_ASSERT_NEXT(a_push_fills_queue, clk, rst_n, q_push && !q_pop, !q_empty)
    `UTRE_ASSERT_IMPLY(a_stall_has_no_bytes, clk, rst_n, !empty && (result.status == ST_STALL), !result.has_byte && result.last)

endmodule

/* tb/tb.sv */
// ---------------------------------------------------------------------------
// USB tablet report engine testbench
// Drives pointer events, control requests and tokens into the report engine,
// predicts every response word in step with the accepted input words, and
// compares each popped result word field by field. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import utre_pkg::*;

    // Codes that the package does not name.
    localparam logic [2:0]  MODE_SPARE6 = 3'd6;
    localparam logic [2:0]  MODE_SPARE7 = 3'd7;
    localparam logic [15:0] REQ_BOGUS   = 16'hFFFF;
    localparam logic [7:0]  FMT_UNKNOWN = 8'hFF;
    localparam logic [15:0] KNOWN_REQ [5] = '{REQ_SET_FORMAT, REQ_GET_FORMAT,
                                              REQ_GET_REPORT, REQ_GET_IDLE,
                                              REQ_SET_IDLE};

    // Tracks device state and the response words the engine owes.
    class tablet_report_tracker;
        result_t     report_words[$];
        int unsigned errors;
        accum_t      acc_dx;
        accum_t      acc_dy;
        accum_t      acc_wheel;
        logic [2:0]  btn_held;
        logic [12:0] px;
        logic [11:0] py;
        logic [7:0]  fmt;
        logic [7:0]  idle;
        bit          changed;
        logic [7:0]  rsp [0:6];

        function new();
            clear_pointer();
            idle    = 8'd0;
            changed = 1'b1;
            errors  = 0;
        endfunction

        // Device reset keeps the idle rate and the change flag.
        function void clear_pointer();
            acc_dx    = '0;
            acc_dy    = '0;
            acc_wheel = '0;
            btn_held  = 3'd0;
            px        = 13'd0;
            py        = 12'd0;
            fmt       = FMT_REL;
        endfunction

        function accum_t sat_sum(accum_t a, logic signed [15:0] d);
            int s;
            s = int'(a) + int'(d);
            if (s > int'(ACC_MAX))
                return ACC_MAX;
            if (s < int'(ACC_MIN))
                return ACC_MIN;
            return accum_t'(s);
        endfunction

        // Takes up to one byte of motion out of an accumulator.
        function logic [7:0] drain8(inout accum_t a);
            int v;
            v = int'(a);
            if (v < int'(CLAMP_LO))
                v = int'(CLAMP_LO);
            if (v > int'(CLAMP_HI))
                v = int'(CLAMP_HI);
            a = accum_t'(int'(a) - v);
            return 8'(v);
        endfunction

        // Fills rsp with the report of the current format and returns its size.
        function int unsigned build_report(int unsigned len);
            logic [7:0] k;
            if (fmt == FMT_REL)
            begin
                rsp[0] = {5'd0, btn_held};
                rsp[1] = drain8(acc_dx);
                rsp[2] = drain8(acc_dy);
                rsp[3] = drain8(acc_wheel);
                return (len >= 4) ? 4 : 3;
            end
            if (fmt == FMT_ABS)
            begin
                if (len < 7)
                    return 0;
                k = 8'h00;
                if (btn_held[1])
                    k = k | ABS_RIGHT;
                if (btn_held[2])
                    k = k | ABS_MIDDLE;
                rsp[0] = fmt;
                rsp[1] = px[7:0];
                rsp[2] = {3'd0, px[12:8]};
                rsp[3] = py[7:0];
                rsp[4] = {4'd0, py[11:8]};
                rsp[5] = k;
                rsp[6] = (btn_held[0] || btn_held[2]) ? 8'h00 : ABS_NOTIP;
                return 7;
            end
            return 0;
        endfunction

        // Queues a response, cut to the host buffer; an empty one is a single word.
        function void queue_response(logic [1:0] st, int unsigned n, int unsigned len);
            result_t r;
            int unsigned i;
            if (n > len)
                n = len;
            r.status = st;
            if (n == 0)
            begin
                r.byte_count = 3'd0;
                r.has_byte   = 1'b0;
                r.byte_value = 8'd0;
                r.last       = 1'b1;
                report_words.push_back(r);
                return;
            end
            for (i = 0; i < n; i++)
            begin
                r.byte_count = 3'(n);
                r.has_byte   = 1'b1;
                r.byte_value = rsp[i];
                r.last       = (i + 1 == n);
                report_words.push_back(r);
            end
        endfunction

        // Applies one accepted input word.
        function void note_word(item_t w);
            int unsigned len;
            len = w.buffer_length;
            case (w.mode)
                MODE_REL:
                begin
                    acc_dx    = sat_sum(acc_dx, w.delta_x);
                    acc_dy    = sat_sum(acc_dy, w.delta_y);
                    acc_wheel = sat_sum(acc_wheel, w.wheel_delta);
                    btn_held  = w.buttons;
                    changed   = 1'b1;
                end
                MODE_ABS:
                begin
                    px = 13'((int'(w.abs_x) * int'(SCALE_X)) / int'(ABS_FULL));
                    py = 12'((int'(w.abs_y) * int'(SCALE_Y)) / int'(ABS_FULL));
                    acc_wheel = sat_sum(acc_wheel, w.wheel_delta);
                    btn_held  = w.buttons;
                    changed   = 1'b1;
                end
                MODE_CTRL:
                begin
                    case (w.request_code)
                        REQ_SET_FORMAT:
                        begin
                            fmt = w.request_data;
                            queue_response(ST_ACK, 0, len);
                        end
                        REQ_GET_FORMAT:
                        begin
                            rsp[0] = 8'h00;
                            rsp[1] = fmt;
                            queue_response(ST_ACK, 2, len);
                        end
                        REQ_GET_REPORT:
                            queue_response(ST_ACK, build_report(len), len);
                        REQ_GET_IDLE:
                        begin
                            rsp[0] = idle;
                            queue_response(ST_ACK, 1, len);
                        end
                        REQ_SET_IDLE:
                        begin
                            idle = w.request_value[15:8];
                            queue_response(ST_ACK, 0, len);
                        end
                        default:
                            queue_response(ST_STALL, 0, len);
                    endcase
                end
                MODE_IN:
                begin
                    if (w.endpoint != REPORT_EP)
                        queue_response(ST_STALL, 0, len);
                    else if (!changed && idle == 8'd0)
                        queue_response(ST_NAK, 0, len);
                    else
                    begin
                        changed = 1'b0;
                        queue_response(ST_ACK, build_report(len), len);
                    end
                end
                MODE_OUT:
                    queue_response(ST_STALL, 0, len);
                MODE_RESET:
                    clear_pointer();
                default:
                    ;
            endcase
        endfunction

        function void diff(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want,
                         got);
                errors++;
            end
        endfunction

        // Compares one popped result word with the oldest one owed.
        function void check_word(result_t got);
            result_t want;
            if (report_words.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h", $time,
                         got);
                errors++;
                return;
            end
            want = report_words.pop_front();
            diff("status", want.status, got.status);
            diff("byte_count", want.byte_count, got.byte_count);
            diff("has_byte", want.has_byte, got.has_byte);
            diff("byte_value", want.byte_value, got.byte_value);
            diff("last", want.last, got.last);
        endfunction

        function void check_leftover();
            if (report_words.size() != 0)
            begin
                $display("%0t: %0d result words never arrived, expected next %h", $time,
                         report_words.size(), report_words[0]);
                errors += report_words.size();
            end
        endfunction
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    push  = 1'b0;
    logic    full;
    item_t   item  = '0;
    logic    empty;
    logic    pop   = 1'b0;
    result_t result;

    bit no_gaps     = 1'b0;
    bit rx_hold_req = 1'b0;

    tablet_report_tracker tracker = new();

    usb_tablet_report_engine i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every field random, so that unused fields toggle too.
    function automatic item_t random_word();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(item_t)-1:0];
    endfunction

    function automatic item_t rel_event(int dx, int dy, int wh, logic [2:0] btn);
        item_t w;
        w = random_word();
        w.mode        = MODE_REL;
        w.delta_x     = 16'(dx);
        w.delta_y     = 16'(dy);
        w.wheel_delta = 16'(wh);
        w.buttons     = btn;
        return w;
    endfunction

    function automatic item_t abs_event(int x, int y, int wh, logic [2:0] btn);
        item_t w;
        w = random_word();
        w.mode        = MODE_ABS;
        w.abs_x       = 15'(x);
        w.abs_y       = 15'(y);
        w.wheel_delta = 16'(wh);
        w.buttons     = btn;
        return w;
    endfunction

    function automatic item_t ctrl_req(logic [15:0] code, logic [15:0] value,
                                       logic [7:0] data, logic [15:0] len);
        item_t w;
        w = random_word();
        w.mode          = MODE_CTRL;
        w.request_code  = code;
        w.request_value = value;
        w.request_data  = data;
        w.buffer_length = len;
        return w;
    endfunction

    function automatic item_t token(logic [2:0] md, logic [3:0] ep, logic [15:0] len);
        item_t w;
        w = random_word();
        w.mode          = md;
        w.endpoint      = ep;
        w.buffer_length = len;
        return w;
    endfunction

    // Mostly modest motion, now and then anything at all.
    function automatic logic [15:0] pick_motion();
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'(int'($urandom_range(0, 400)) - 200);
    endfunction

    function automatic logic [15:0] pick_len();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 8));
    endfunction

    // Offers one word, with an occasional gap first, and waits until it is taken.
    task automatic offer(item_t w);
        if (!no_gaps && $urandom_range(0, 4) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        push <= 1'b1;
        item <= w;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tracker.note_word(w);
    endtask

    // Holds the input side until every owed result word has been popped.
    task automatic wait_drained();
        push <= 1'b0;
        do
            @(posedge clk);
        while (tracker.report_words.size() != 0);
    endtask

    // Mostly well-formed traffic with random content, some stalls and noise.
    task automatic random_phase(int count);
        item_t w;
        int    sent;
        int    pick;
        sent = 0;
        while (sent < count)
        begin
            w = random_word();
            w.buffer_length = pick_len();
            pick = $urandom_range(0, 99);
            sent++;
            if (pick < 20)
            begin
                w.mode        = MODE_REL;
                w.delta_x     = pick_motion();
                w.delta_y     = pick_motion();
                w.wheel_delta = pick_motion();
            end
            else if (pick < 33)
            begin
                w.mode        = MODE_ABS;
                w.wheel_delta = pick_motion();
            end
            else if (pick < 58)
            begin
                w.mode         = MODE_CTRL;
                w.request_code = KNOWN_REQ[$urandom_range(0, 4)];
                case ($urandom_range(0, 5))
                    0, 1, 2: w.request_data = FMT_REL;
                    3, 4:    w.request_data = FMT_ABS;
                    default: ;
                endcase
                if ($urandom_range(0, 1) == 0)
                    w.request_value[15:8] = 8'd0;
            end
            else if (pick < 85)
            begin
                w.mode = MODE_IN;
                if (pick < 82)
                    w.endpoint = REPORT_EP;
            end
            else if (pick < 89)
                w.mode = MODE_OUT;
            else if (pick < 93)
                w.mode = MODE_CTRL;
            else if (pick < 96)
                w.mode = MODE_RESET;
            else
            begin
                w.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE6 : MODE_SPARE7;
                sent--;
            end
            offer(w);
        end
    endtask

    // Result side: pops with random gaps, and one long hold on request.
    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                tracker.check_word(result);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!no_gaps && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(0, 3);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Run limit.
    initial
    begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pending change after reset, then nothing new.
        offer(token(MODE_IN, REPORT_EP, 16'd8));
        offer(token(MODE_IN, REPORT_EP, 16'd8));
        // Accumulators driven into saturation.
        offer(rel_event(32767, -32768, 32767, 3'd7));
        offer(rel_event(32767, -32768, -32768, 3'd0));
        // Short buffer still drains the wheel.
        offer(token(MODE_IN, REPORT_EP, 16'd3));
        offer(ctrl_req(REQ_GET_REPORT, 16'h0000, 8'h00, 16'hFFFF));
        // Wrong endpoint, OUT token and unknown requests stall.
        offer(token(MODE_IN, 4'd0, 16'd8));
        offer(token(MODE_IN, 4'd15, 16'd8));
        offer(token(MODE_OUT, REPORT_EP, 16'd8));
        offer(ctrl_req(REQ_BOGUS, 16'hFFFF, 8'hFF, 16'd8));
        offer(ctrl_req(REQ_GET_FORMAT, 16'h0000, 8'h00, 16'd1));
        // Absolute format, with a short and a full buffer.
        offer(ctrl_req(REQ_SET_FORMAT, 16'h0000, FMT_ABS, 16'd0));
        offer(abs_event(32767, 32767, -32768, 3'd2));
        offer(token(MODE_IN, REPORT_EP, 16'd6));
        offer(abs_event(0, 0, 0, 3'd1));
        offer(token(MODE_IN, REPORT_EP, 16'd7));
        offer(abs_event(12345, 20000, 5, 3'd4));
        offer(ctrl_req(REQ_GET_REPORT, 16'h0000, 8'h00, 16'hFFFF));
        // Idle rate alone lets IN tokens through.
        offer(ctrl_req(REQ_SET_IDLE, 16'hFF00, 8'h00, 16'd0));
        offer(ctrl_req(REQ_GET_IDLE, 16'h0000, 8'h00, 16'd1));
        offer(token(MODE_IN, REPORT_EP, 16'd7));
        offer(token(MODE_IN, REPORT_EP, 16'd7));
        // Unknown format acknowledges with no bytes.
        offer(ctrl_req(REQ_SET_FORMAT, 16'h0000, FMT_UNKNOWN, 16'd8));
        offer(token(MODE_IN, REPORT_EP, 16'd8));
        // Device reset restores the relative format; spare modes are ignored.
        offer(token(MODE_RESET, 4'd0, 16'd0));
        offer(ctrl_req(REQ_GET_FORMAT, 16'h0000, 8'h00, 16'd2));
        offer(token(MODE_SPARE6, REPORT_EP, 16'd8));
        offer(token(MODE_SPARE7, REPORT_EP, 16'd8));
        offer(ctrl_req(REQ_SET_IDLE, 16'h0000, 8'h00, 16'd0));

        random_phase(50);

        // Receiver holds off while words keep coming, so the input backs up.
        rx_hold_req = 1'b1;
        random_phase(30);

        // Sender pauses until everything owed has come out.
        wait_drained();
        random_phase(80);

        // Last stretch without gaps on either side.
        no_gaps = 1'b1;
        random_phase(30);

        wait_drained();
        repeat (20) @(posedge clk);
        tracker.check_leftover();
        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/utre_pkg.sv
rtl/utre_front.sv
rtl/utre_queue.sv
rtl/utre_exec.sv
rtl/utre_serial.sv
rtl/usb_tablet_report_engine.sv
tb/tb.sv
